### src/rpu_pkg.sv
// ----------------------------------------------------------------------------
// rpu_pkg
// Relocation types, operation classes and encoding constants shared by the
// relocation patch unit.
// ----------------------------------------------------------------------------
package rpu_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned OUTCOME_W = 2;

  localparam logic [CMD_W-1:0] TYPE_NONE     = 8'd0;
  localparam logic [CMD_W-1:0] TYPE_ABS32    = 8'd2;
  localparam logic [CMD_W-1:0] TYPE_THM_CALL = 8'd10;
  localparam logic [CMD_W-1:0] TYPE_RELATIVE = 8'd23;
  localparam logic [CMD_W-1:0] TYPE_CALL     = 8'd28;
  localparam logic [CMD_W-1:0] TYPE_JUMP24   = 8'd29;
  localparam logic [CMD_W-1:0] TYPE_TARGET1  = 8'd38;
  localparam logic [CMD_W-1:0] TYPE_V4BX     = 8'd40;

  localparam logic [OUTCOME_W-1:0] OUT_APPLIED = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_IGNORED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_SKIPPED = 2'd2;

  localparam logic [15:0]       FIRST_KEEP_MASK  = 16'hf800;
  localparam logic [15:0]       SECOND_KEEP_MASK = 16'hc000;
  localparam logic [WORD_W-1:0] PC_BIAS          = 32'd4;

  typedef enum logic [2:0] {
    OP_ABS  = 3'd0,
    OP_REL  = 3'd1,
    OP_THM  = 3'd2,
    OP_IGN  = 3'd3,
    OP_SKIP = 3'd4
  } op_t;

  function automatic op_t decode_cmd(input logic [CMD_W-1:0] cmd);
    op_t op;
    case (cmd)
      TYPE_ABS32, TYPE_TARGET1: op = OP_ABS;
      TYPE_RELATIVE:            op = OP_REL;
      TYPE_THM_CALL:            op = OP_THM;
      TYPE_NONE, TYPE_CALL, TYPE_JUMP24, TYPE_V4BX: op = OP_IGN;
      default:                  op = OP_SKIP;
    endcase
    return op;
  endfunction

  function automatic logic [OUTCOME_W-1:0] op_outcome(input op_t op);
    logic [OUTCOME_W-1:0] code;
    case (op)
      OP_ABS, OP_REL, OP_THM: code = OUT_APPLIED;
      OP_IGN:                 code = OUT_IGNORED;
      default:                code = OUT_SKIPPED;
    endcase
    return code;
  endfunction

endpackage

### src/rpu_thm_enc.sv
// ----------------------------------------------------------------------------
// rpu_thm_enc
// Re-encodes a Thumb BL halfword pair from a branch offset.
// ----------------------------------------------------------------------------
module rpu_thm_enc
  import rpu_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [WORD_W-1:0] rel,
  output logic [WORD_W-1:0] enc_word
);

  logic        s_bit;
  logic        j1;
  logic        j2;
  logic [15:0] first;
  logic [15:0] second;

  assign s_bit = rel[24];
  assign j1    = ~(rel[23] ^ s_bit);
  assign j2    = ~(rel[22] ^ s_bit);

  assign first  = (word[15:0] & FIRST_KEEP_MASK) | {5'd0, s_bit, rel[21:12]};
  assign second = (word[31:16] & SECOND_KEEP_MASK) | {2'd0, j1, 1'b1, j2, rel[11:1]};

  assign enc_word = {second, first};

endmodule

### src/relocation_patch_unit.sv
// ----------------------------------------------------------------------------
// relocation_patch_unit
// Applies one relocation record to one 32-bit word and returns the patched
// word with an outcome code.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_cmd, in_old_word, in_word_address,
//                     in_sym_value, in_addend
// out      output     out_valid, out_stall, out_new_word, out_outcome
//
// Three register stages: sums, branch offset, encode and select. One item
// enters per cycle while in_stall is low. Each stage has its own valid bit
// and holds only when it is full and the stage after it holds, so bubbles
// collapse and in_stall rises only when all three stages are full and the
// output is stalled. Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module relocation_patch_unit
  import rpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [WORD_W-1:0]    in_old_word,
  input  logic [WORD_W-1:0]    in_word_address,
  input  logic [WORD_W-1:0]    in_sym_value,
  input  logic [WORD_W-1:0]    in_addend,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_new_word,
  output logic [OUTCOME_W-1:0] out_outcome
);

  logic adv1;
  logic adv2;
  logic adv3;

  logic              v1_r;
  op_t               op1_r;
  logic [WORD_W-1:0] word1_r;
  logic [WORD_W-1:0] dest1_r;
  logic [WORD_W-1:0] addr4_r;
  logic [WORD_W-1:0] relsum1_r;

  logic              v2_r;
  op_t               op2_r;
  logic [WORD_W-1:0] word2_r;
  logic [WORD_W-1:0] dest2_r;
  logic [WORD_W-1:0] relsum2_r;
  logic [WORD_W-1:0] rel_r;
  logic [WORD_W-1:0] rel_nxt;

  logic                 out_valid_r;
  logic [WORD_W-1:0]    new_word_r;
  logic [WORD_W-1:0]    new_word_nxt;
  logic [OUTCOME_W-1:0] outcome_r;
  logic [WORD_W-1:0]    thm_word;

  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // stage 1: sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1_r     <= decode_cmd(in_cmd);
      word1_r   <= in_old_word;
      dest1_r   <= in_sym_value + in_addend;
      addr4_r   <= in_word_address + PC_BIAS;
      relsum1_r <= in_old_word + in_addend;
    end
  end

  // stage 2: branch offset
  assign rel_nxt = ((dest1_r | 32'd1) - addr4_r) & ~32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      op2_r     <= op1_r;
      word2_r   <= word1_r;
      dest2_r   <= dest1_r;
      relsum2_r <= relsum1_r;
      rel_r     <= rel_nxt;
    end
  end

  // stage 3: encode and select
  rpu_thm_enc u_thm_enc (
    .word     (word2_r),
    .rel      (rel_r),
    .enc_word (thm_word)
  );

  always_comb begin
    case (op2_r)
      OP_ABS:  new_word_nxt = dest2_r;
      OP_REL:  new_word_nxt = relsum2_r;
      OP_THM:  new_word_nxt = thm_word;
      default: new_word_nxt = word2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      new_word_r <= new_word_nxt;
      outcome_r  <= op_outcome(op2_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_new_word = new_word_r;
  assign out_outcome  = outcome_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item lost at stage 1");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv2) |=> (v2_r && $stable(rel_r) && $stable(op2_r)))
    else $error("held stage 2 item changed");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == OUT_APPLIED || out_outcome == OUT_IGNORED
                   || out_outcome == OUT_SKIPPED))
    else $error("bad outcome code");

endmodule
